>>> sv/rtha_pkg.sv
// Package for the region table heap allocator: sizes, codes and types.
// Used by the channel interfaces, the allocator top level and the testbench.
`default_nettype none
package rtha_pkg;

    localparam int MAX_REGIONS = 256;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PAGE_BYTES  = 4096;
    localparam int SEG_BYTES   = 65536;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_GROW  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BND_NONE  = 2'd0,
        BND_PAGE  = 2'd1,
        BND_SEG   = 2'd2,
        BND_NONE2 = 2'd3
    } t_bnd_mode;

    typedef enum logic [0:0] {
        CFG_HEAP_BASE  = 1'd0,
        CFG_MIN_GROWTH = 1'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_PRE,
        S_A_LEFT,
        S_A_SPLIT,
        S_A_TAIL,
        S_F_RD,
        S_F_EV,
        S_F_MRG,
        S_G_EV,
        S_SHIFT,
        S_DONE
    } t_state;

    // One table entry as stored in the region memory
    typedef struct packed {
        logic        res;
        logic [31:0] sz;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

>>> sv/rtha_req_if.sv
// Request channel of the allocator: valid/ready plus one request.
// Depends on rtha_pkg for the code types.
`default_nettype none
interface rtha_req_if;
    logic                  valid;
    logic                  ready;
    rtha_pkg::t_opcode     opcode;
    logic [31:0]           size;
    logic [16:0]           align_bytes;
    rtha_pkg::t_bnd_mode   boundary_mode;
    logic [31:0]           free_addr;

    modport source (output valid, opcode, size, align_bytes, boundary_mode, free_addr,
                    input ready);
    modport sink   (input valid, opcode, size, align_bytes, boundary_mode, free_addr,
                    output ready);
endinterface
`default_nettype wire

>>> sv/rtha_rsp_if.sv
// Response channel of the allocator: valid/ready plus one result.
// Depends on rtha_pkg for the status type.
`default_nettype none
interface rtha_rsp_if;
    logic              valid;
    logic              ready;
    logic [31:0]       result_addr;
    rtha_pkg::t_status status;
    logic [31:0]       grow_bytes;
    logic [31:0]       heap_bytes;

    modport source (output valid, result_addr, status, grow_bytes, heap_bytes,
                    input ready);
    modport sink   (input valid, result_addr, status, grow_bytes, heap_bytes,
                    output ready);
endinterface
`default_nettype wire

>>> sv/rtha_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on rtha_pkg for the register index type.
`default_nettype none
interface rtha_cfg_if;
    logic               valid;
    logic               ready;
    rtha_pkg::t_cfg_idx index;
    logic [31:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/rtha_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module rtha_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/region_table_heap_allocator.sv
// Region table heap allocator: top level with the table walk sequencer.
// A request walks the regions one by one and shifts the table entries above an
// inserted or removed slot one entry at a time.
// One request at a time; the region memory's single read port sets the rate.
// Reset (synchronous, active low) empties the table and restores the
// register defaults; the region memory itself is not cleared.
`default_nettype none
module region_table_heap_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rtha_req_if.sink   i_req,
    rtha_rsp_if.source o_rsp,
    rtha_cfg_if.sink   i_cfg
);
    localparam int IW = rtha_pkg::IDX_W;
    localparam int CW = rtha_pkg::CNT_W;
    localparam logic [CW-1:0] MAXC = CW'(rtha_pkg::MAX_REGIONS);
    localparam logic [31:0] PG    = 32'(rtha_pkg::PAGE_BYTES);
    localparam logic [31:0] SG    = 32'(rtha_pkg::SEG_BYTES);
    localparam logic [34:0] PGM   = 35'(rtha_pkg::PAGE_BYTES - 1);

    // control state
    rtha_pkg::t_state r_state, n_state, r_sh_ret, n_sh_ret;
    logic [CW-1:0] r_cnt, n_cnt, r_ffi, n_ffi;
    logic [31:0]   r_ffa, n_ffa, r_total, n_total, r_base, n_base, r_ming, n_ming;
    logic          r_ovld, n_ovld, r_sh_pend, n_sh_pend;

    // working payload
    logic [32:0]   r_need, n_need;
    logic [16:0]   r_am, n_am, r_pad, n_pad;
    rtha_pkg::t_bnd_mode r_mode, n_mode;
    logic [31:0]   r_tgt, n_tgt, r_bytes, n_bytes, r_addr, n_addr, r_sz, n_sz;
    logic [31:0]   r_psz, n_psz, r_ra, n_ra, r_grow, n_grow;
    logic [CW-1:0] r_i, n_i, r_sh_j, n_sh_j, r_sh_left, n_sh_left;
    logic [IW-1:0] r_sh_wa, n_sh_wa;
    logic [1:0]    r_sh_k, n_sh_k;
    logic          r_seen, n_seen, r_hprev, n_hprev, r_pres, n_pres, r_hnxt, n_hnxt;
    logic          r_sh_up, n_sh_up;
    rtha_pkg::t_status r_st, n_st;
    logic [31:0]   r_o_ra, n_o_ra, r_o_grow, n_o_grow, r_o_heap, n_o_heap;
    rtha_pkg::t_status r_o_st, n_o_st;

    // memory port
    logic          ram_we;
    logic [IW-1:0] ram_wa, ram_ra;
    rtha_pkg::t_entry ram_wd, rd;
    logic [rtha_pkg::ENTRY_W-1:0] ram_rdata;

    // combinational helpers
    logic [16:0]   smear;
    logic [31:0]   aligned, pad32, rem, lim, cur;
    logic [33:0]   fit_need;
    logic [34:0]   g3, gr;
    logic          fit, bnd_ok, nfree, pfree, match;
    logic [31:0]   room, gbytes;
    logic [CW-1:0] cm1, ip1, kk, m_idx;
    logic [31:0]   m_addr;

    rtha_ram #(.W(rtha_pkg::ENTRY_W), .D(rtha_pkg::MAX_REGIONS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rdata)
    );
    assign rd = rtha_pkg::t_entry'(ram_rdata);

    assign i_req.ready       = (r_state == rtha_pkg::S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_ovld;
    assign o_rsp.result_addr = r_o_ra;
    assign o_rsp.status      = r_o_st;
    assign o_rsp.grow_bytes  = r_o_grow;
    assign o_rsp.heap_bytes  = r_o_heap;

    // alignment, boundary and fit tests for the region at r_addr, plus growth and merge helpers
    always_comb begin
        smear = i_req.align_bytes;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        aligned  = (r_addr + {15'd0, r_am}) & ~{15'd0, r_am};
        pad32    = aligned - r_addr;
        unique case (r_mode)
            rtha_pkg::BND_PAGE: begin
                rem = r_addr & (PG - 32'd1);
                lim = PG - rem;
            end
            rtha_pkg::BND_SEG: begin
                rem = r_addr & (SG - 32'd1);
                lim = SG - rem;
            end
            default: begin
                rem = (r_addr == 32'hFFFF_FFFF) ? 32'd0 : r_addr;
                lim = 32'hFFFF_FFFF - rem;
            end
        endcase
        bnd_ok   = lim >= pad32;
        fit_need = {1'b0, r_need} + {2'd0, pad32};
        fit      = !rd.res && ({2'd0, rd.sz} >= fit_need) && bnd_ok;
        // suggested growth: page-rounded 1.5 * need, floored by min_growth
        g3 = {2'd0, r_need} + {1'b0, r_need, 1'b0};
        gr = ({1'b0, g3[34:1]} + PGM) & ~PGM;
        if (gr < {3'd0, r_ming}) begin
            gr = {3'd0, r_ming};
        end
        if (gr[34:32] != 3'd0) begin
            gr = 35'h0_FFFF_FFFF;
        end
        room   = ~r_total;
        gbytes = (i_req.size > room) ? room : i_req.size;
        match  = (r_addr == r_tgt) && rd.res;
        nfree  = r_hnxt && !rd.res;
        pfree  = r_hprev && !r_pres;
        cur    = r_sz + (nfree ? rd.sz : 32'd0);
        cm1    = r_cnt - CW'(1);
        ip1    = r_i + CW'(1);
        kk     = nfree ? CW'(2) : CW'(1);
    end

    // next state, memory access and result
    always_comb begin
        n_state = r_state;   n_sh_ret = r_sh_ret;
        n_cnt = r_cnt;       n_ffi = r_ffi;       n_ffa = r_ffa;
        n_total = r_total;   n_base = r_base;     n_ming = r_ming;
        n_ovld = r_ovld & ~o_rsp.ready;
        n_sh_pend = r_sh_pend;
        n_need = r_need;     n_am = r_am;         n_pad = r_pad;    n_mode = r_mode;
        n_tgt = r_tgt;       n_bytes = r_bytes;   n_addr = r_addr;  n_sz = r_sz;
        n_psz = r_psz;       n_ra = r_ra;         n_grow = r_grow;
        n_i = r_i;           n_sh_j = r_sh_j;     n_sh_left = r_sh_left;
        n_sh_wa = r_sh_wa;   n_sh_k = r_sh_k;     n_sh_up = r_sh_up;
        n_seen = r_seen;     n_hprev = r_hprev;   n_pres = r_pres;  n_hnxt = r_hnxt;
        n_st = r_st;
        n_o_ra = r_o_ra;     n_o_st = r_o_st;     n_o_grow = r_o_grow; n_o_heap = r_o_heap;
        m_idx  = r_i;
        m_addr = r_addr;
        ram_we = 1'b0;
        ram_wa = r_i[IW-1:0];
        ram_wd = '{res: 1'b0, sz: 32'd0};
        ram_ra = r_i[IW-1:0];

        // configuration writes; the base moves the first-free address along
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rtha_pkg::CFG_HEAP_BASE: begin
                    n_ffa  = r_ffa + (i_cfg.data - r_base);
                    n_base = i_cfg.data;
                end
                rtha_pkg::CFG_MIN_GROWTH: n_ming = i_cfg.data;
                default: ;
            endcase
        end

        unique case (r_state)
            rtha_pkg::S_IDLE: begin
                ram_ra = cm1[IW-1:0];
                if (i_req.valid) begin
                    n_need  = ({1'b0, i_req.size} + 33'd3) & ~33'd3;
                    n_am    = smear >> 1;
                    n_mode  = i_req.boundary_mode;
                    n_tgt   = i_req.free_addr;
                    n_bytes = gbytes;
                    n_st    = rtha_pkg::ST_OK;
                    n_ra    = 32'd0;
                    n_grow  = 32'd0;
                    unique case (i_req.opcode)
                        rtha_pkg::OP_ALLOC: begin
                            n_i     = r_ffi;
                            n_addr  = r_ffa;
                            n_seen  = 1'b0;
                            n_state = rtha_pkg::S_A_RD;
                        end
                        rtha_pkg::OP_FREE: begin
                            n_i     = '0;
                            n_addr  = r_base;
                            n_hprev = 1'b0;
                            n_state = (i_req.free_addr == 32'd0) ? rtha_pkg::S_DONE
                                                                 : rtha_pkg::S_F_RD;
                        end
                        rtha_pkg::OP_GROW: begin
                            n_hnxt  = (r_cnt != '0);
                            n_state = (gbytes == 32'd0) ? rtha_pkg::S_DONE
                                                        : rtha_pkg::S_G_EV;
                        end
                        default: n_state = rtha_pkg::S_DONE;
                    endcase
                end
            end

            // allocate: walk from the cached first-free region
            rtha_pkg::S_A_RD: begin
                if (r_i >= r_cnt) begin
                    n_st    = rtha_pkg::ST_NOFIT;
                    n_grow  = gr[31:0];
                    n_state = rtha_pkg::S_DONE;
                end else begin
                    n_state = rtha_pkg::S_A_EV;
                end
            end
            rtha_pkg::S_A_EV: begin
                if (!rd.res) begin
                    n_seen = 1'b1;
                end else if (!r_seen) begin
                    n_ffi = r_i;
                    n_ffa = r_addr;
                end
                if (fit) begin
                    n_sz  = rd.sz;
                    n_pad = pad32[16:0];
                    if (pad32 != 32'd0) begin
                        if (r_cnt >= MAXC) begin
                            n_st    = rtha_pkg::ST_FULL;
                            n_state = rtha_pkg::S_DONE;
                        end else begin
                            // open a slot at i for the free pad region
                            n_sh_up   = 1'b1;
                            n_sh_j    = cm1;
                            n_sh_left = r_cnt - r_i;
                            n_sh_pend = 1'b0;
                            n_cnt     = r_cnt + CW'(1);
                            n_sh_ret  = rtha_pkg::S_A_PRE;
                            n_state   = rtha_pkg::S_SHIFT;
                        end
                    end else begin
                        n_state = rtha_pkg::S_A_LEFT;
                    end
                end else begin
                    n_addr  = r_addr + rd.sz;
                    n_i     = ip1;
                    n_state = rtha_pkg::S_A_RD;
                end
            end
            rtha_pkg::S_A_PRE: begin
                ram_we  = 1'b1;
                ram_wd  = '{res: 1'b0, sz: {15'd0, r_pad}};
                n_sz    = r_sz - {15'd0, r_pad};
                n_addr  = r_addr + {15'd0, r_pad};
                n_i     = ip1;
                n_state = rtha_pkg::S_A_LEFT;
            end
            rtha_pkg::S_A_LEFT: begin
                if ({1'b0, r_sz} > r_need) begin
                    if (r_cnt >= MAXC) begin
                        // keep the region free, trimmed by any pad split
                        ram_we  = 1'b1;
                        ram_wd  = '{res: 1'b0, sz: r_sz};
                        n_st    = rtha_pkg::ST_FULL;
                        n_state = rtha_pkg::S_DONE;
                    end else begin
                        // open a slot after i for the free leftover
                        n_sh_up   = 1'b1;
                        n_sh_j    = cm1;
                        n_sh_left = r_cnt - ip1;
                        n_sh_pend = 1'b0;
                        n_cnt     = r_cnt + CW'(1);
                        n_sh_ret  = rtha_pkg::S_A_SPLIT;
                        n_state   = rtha_pkg::S_SHIFT;
                    end
                end else begin
                    ram_we  = 1'b1;
                    ram_wd  = '{res: 1'b1, sz: r_sz};
                    n_ra    = r_addr;
                    n_state = rtha_pkg::S_DONE;
                end
            end
            rtha_pkg::S_A_SPLIT: begin
                ram_we  = 1'b1;
                ram_wd  = '{res: 1'b1, sz: r_need[31:0]};
                n_ra    = r_addr;
                n_state = rtha_pkg::S_A_TAIL;
            end
            rtha_pkg::S_A_TAIL: begin
                ram_we  = 1'b1;
                ram_wa  = ip1[IW-1:0];
                ram_wd  = '{res: 1'b0, sz: r_sz - r_need[31:0]};
                n_state = rtha_pkg::S_DONE;
            end

            // free: walk from the base looking for the exact address
            rtha_pkg::S_F_RD: begin
                if (r_i >= r_cnt) begin
                    n_st    = rtha_pkg::ST_UNKNOWN;
                    n_state = rtha_pkg::S_DONE;
                end else begin
                    n_state = rtha_pkg::S_F_EV;
                end
            end
            rtha_pkg::S_F_EV: begin
                ram_ra = ip1[IW-1:0];
                if (match) begin
                    n_sz    = rd.sz;
                    n_hnxt  = (ip1 < r_cnt);
                    n_state = rtha_pkg::S_F_MRG;
                end else begin
                    n_hprev = 1'b1;
                    n_psz   = rd.sz;
                    n_pres  = rd.res;
                    n_addr  = r_addr + rd.sz;
                    n_i     = ip1;
                    n_state = rtha_pkg::S_F_RD;
                end
            end
            rtha_pkg::S_F_MRG: begin
                ram_we    = 1'b1;
                n_sh_up   = 1'b0;
                n_sh_pend = 1'b0;
                n_sh_ret  = rtha_pkg::S_DONE;
                n_state   = rtha_pkg::S_SHIFT;
                if (pfree) begin
                    // fold into the previous region and drop i (and i+1)
                    ram_wa    = cm1[IW-1:0] - cm1[IW-1:0] + (r_i[IW-1:0] - IW'(1));
                    ram_wd    = '{res: 1'b0, sz: r_psz + cur};
                    n_sh_k    = kk[1:0];
                    n_sh_j    = r_i + kk;
                    n_sh_left = r_cnt - r_i - kk;
                    n_cnt     = r_cnt - kk;
                    m_idx     = r_i - CW'(1);
                    m_addr    = r_addr - r_psz;
                end else begin
                    ram_wd    = '{res: 1'b0, sz: cur};
                    n_sh_k    = 2'd1;
                    n_sh_j    = r_i + CW'(2);
                    n_sh_left = nfree ? (r_cnt - r_i - CW'(2)) : '0;
                    n_cnt     = nfree ? cm1 : r_cnt;
                end
                if (m_idx < r_ffi) begin
                    n_ffi = m_idx;
                    n_ffa = m_addr;
                end
            end

            // grow: extend a free last region or append a new one
            rtha_pkg::S_G_EV: begin
                if (r_hnxt && !rd.res) begin
                    ram_we  = 1'b1;
                    ram_wa  = cm1[IW-1:0];
                    ram_wd  = '{res: 1'b0, sz: rd.sz + r_bytes};
                    n_total = r_total + r_bytes;
                end else if (r_cnt >= MAXC) begin
                    n_st = rtha_pkg::ST_FULL;
                end else begin
                    ram_we  = 1'b1;
                    ram_wa  = r_cnt[IW-1:0];
                    ram_wd  = '{res: 1'b0, sz: r_bytes};
                    n_cnt   = r_cnt + CW'(1);
                    n_total = r_total + r_bytes;
                end
                n_state = rtha_pkg::S_DONE;
            end

            // move entries up or down by one read and one write per cycle
            rtha_pkg::S_SHIFT: begin
                ram_ra = r_sh_j[IW-1:0];
                if (r_sh_pend) begin
                    ram_we = 1'b1;
                    ram_wa = r_sh_wa;
                    ram_wd = rd;
                end
                if (r_sh_left != '0) begin
                    n_sh_pend = 1'b1;
                    if (r_sh_up) begin
                        n_sh_wa = r_sh_j[IW-1:0] + IW'(1);
                        n_sh_j  = r_sh_j - CW'(1);
                    end else begin
                        n_sh_wa = r_sh_j[IW-1:0] - IW'(r_sh_k);
                        n_sh_j  = r_sh_j + CW'(1);
                    end
                    n_sh_left = r_sh_left - CW'(1);
                end else begin
                    n_sh_pend = 1'b0;
                    if (!r_sh_pend) begin
                        n_state = r_sh_ret;
                    end
                end
            end

            // hand the result to the output register
            rtha_pkg::S_DONE: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld   = 1'b1;
                    n_o_st   = r_st;
                    n_o_ra   = (r_st == rtha_pkg::ST_OK) ? r_ra : 32'd0;
                    n_o_grow = (r_st == rtha_pkg::ST_NOFIT) ? r_grow : 32'd0;
                    n_o_heap = r_total;
                    n_state  = rtha_pkg::S_IDLE;
                end
            end
            default: n_state = rtha_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rtha_pkg::S_IDLE;
            r_cnt     <= '0;
            r_ffi     <= '0;
            r_ffa     <= 32'd0;
            r_total   <= 32'd0;
            r_base    <= 32'd0;
            r_ming    <= 32'd65536;
            r_ovld    <= 1'b0;
            r_sh_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ffi     <= n_ffi;
            r_ffa     <= n_ffa;
            r_total   <= n_total;
            r_base    <= n_base;
            r_ming    <= n_ming;
            r_ovld    <= n_ovld;
            r_sh_pend <= n_sh_pend;
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        r_sh_ret  <= n_sh_ret;
        r_need    <= n_need;
        r_am      <= n_am;
        r_pad     <= n_pad;
        r_mode    <= n_mode;
        r_tgt     <= n_tgt;
        r_bytes   <= n_bytes;
        r_addr    <= n_addr;
        r_sz      <= n_sz;
        r_psz     <= n_psz;
        r_ra      <= n_ra;
        r_grow    <= n_grow;
        r_i       <= n_i;
        r_sh_j    <= n_sh_j;
        r_sh_left <= n_sh_left;
        r_sh_wa   <= n_sh_wa;
        r_sh_k    <= n_sh_k;
        r_sh_up   <= n_sh_up;
        r_seen    <= n_seen;
        r_hprev   <= n_hprev;
        r_pres    <= n_pres;
        r_hnxt    <= n_hnxt;
        r_st      <= n_st;
        r_o_ra    <= n_o_ra;
        r_o_st    <= n_o_st;
        r_o_grow  <= n_o_grow;
        r_o_heap  <= n_o_heap;
    end
endmodule
`default_nettype wire

>>> tb/sv/tb_region_table_heap_allocator.sv
// Self-checking bench for region_table_heap_allocator: directed table, then random traffic.
// Depends on rtha_pkg and the rtha_req_if, rtha_rsp_if and rtha_cfg_if channel interfaces.
// A built-in model of the region table predicts each response (directed rows may fix it) and checks it field by field.
`default_nettype none
module tb_region_table_heap_allocator;
    import rtha_pkg::*;

    localparam int          ITEM_TARGET = 1170;
    localparam int          WATCH_LIMIT = 20000;
    localparam logic [31:0] GROW_CAP    = 32'h0100_0000;

    typedef struct {
        logic [31:0] addr;
        t_status     st;
        logic [31:0] grow;
        logic [31:0] heap;
    } heap_reply_t;

    typedef struct {
        t_opcode     op;
        logic [31:0] size;
        logic [16:0] align;
        t_bnd_mode   mode;
        logic [31:0] faddr;
        bit          typed;
        heap_reply_t want;
    } heap_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rtha_req_if req_ch();
    rtha_rsp_if rsp_ch();
    rtha_cfg_if cfg_ch();

    region_table_heap_allocator uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Model of the region table
    logic [31:0] tbl_size [MAX_REGIONS];
    bit          tbl_res  [MAX_REGIONS];
    int unsigned tbl_count;
    int unsigned first_free_idx;
    logic [31:0] first_free_addr;
    logic [31:0] heap_total;
    logic [31:0] base_reg;
    logic [31:0] min_grow_reg;

    heap_reply_t replies_due[$];
    logic [31:0] live_addrs[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void open_slot(input int unsigned pos);
        for (int unsigned k = tbl_count; k > pos; k--) begin
            tbl_size[k] = tbl_size[k-1];
            tbl_res[k]  = tbl_res[k-1];
        end
        tbl_count++;
    endfunction

    function automatic void close_slot(input int unsigned pos);
        for (int unsigned k = pos; k + 1 < tbl_count; k++) begin
            tbl_size[k] = tbl_size[k+1];
            tbl_res[k]  = tbl_res[k+1];
        end
        tbl_count--;
    endfunction

    function automatic t_status model_alloc(input logic [31:0] req, input logic [16:0] align_in,
                                            input t_bnd_mode mode, output logic [31:0] a_out,
                                            output logic [31:0] g_out);
        logic [63:0] need;
        logic [63:0] g;
        logic [31:0] align;
        logic [31:0] bnd_lim;
        logic [31:0] addr;
        logic [31:0] aligned;
        logic [31:0] pad;
        bit          seen_free;
        int unsigned i;
        need      = (64'(req) + 64'd3) & ~64'd3;
        align     = 32'd1;
        bnd_lim   = 32'hFFFF_FFFF;
        addr      = first_free_addr;
        seen_free = 1'b0;
        a_out     = '0;
        g_out     = '0;
        // highest set bit is the alignment
        for (int b = 0; b < 17; b++)
            if (align_in[b])
                align = 32'd1 << b;
        if (mode == BND_PAGE)
            bnd_lim = PAGE_BYTES;
        else if (mode == BND_SEG)
            bnd_lim = SEG_BYTES;
        i = first_free_idx;
        while (i < tbl_count) begin
            aligned = (addr + (align - 1)) & ~(align - 1);
            pad     = aligned - addr;
            if (!tbl_res[i])
                seen_free = 1'b1;
            else if (!seen_free) begin
                first_free_idx  = i;
                first_free_addr = addr;
            end
            if (!tbl_res[i] && 64'(tbl_size[i]) >= need + 64'(pad) &&
                bnd_lim - (addr % bnd_lim) >= pad) begin
                if (pad != 0) begin
                    if (tbl_count >= MAX_REGIONS)
                        return ST_FULL;
                    open_slot(i);
                    tbl_size[i]    = pad;
                    tbl_res[i]     = 1'b0;
                    tbl_size[i+1] -= pad;
                    addr          += pad;
                    i++;
                end
                if (64'(tbl_size[i]) > need) begin
                    if (tbl_count + 1 > MAX_REGIONS)
                        return ST_FULL;
                    open_slot(i + 1);
                    tbl_size[i+1] = tbl_size[i] - need[31:0];
                    tbl_res[i+1]  = 1'b0;
                    tbl_size[i]   = need[31:0];
                end
                tbl_res[i] = 1'b1;
                a_out      = addr;
                return ST_OK;
            end
            addr += tbl_size[i];
            i++;
        end
        g = need * 3 / 2;
        g = (g + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
        if (g < 64'(min_grow_reg))
            g = 64'(min_grow_reg);
        if (g > 64'hFFFF_FFFF)
            g = 64'hFFFF_FFFF;
        g_out = g[31:0];
        return ST_NOFIT;
    endfunction

    function automatic t_status model_free(input logic [31:0] target);
        logic [31:0] addr;
        int unsigned m;
        addr = base_reg;
        if (target == 0)
            return ST_OK;
        for (int unsigned i = 0; i < tbl_count; i++) begin
            if (addr == target && tbl_res[i]) begin
                m          = i;
                tbl_res[i] = 1'b0;
                // merge with the free neighbor after, then before
                if (i + 1 < tbl_count && !tbl_res[i+1]) begin
                    tbl_size[i] += tbl_size[i+1];
                    close_slot(i + 1);
                end
                if (i > 0 && !tbl_res[i-1]) begin
                    addr          -= tbl_size[i-1];
                    tbl_size[i-1] += tbl_size[i];
                    close_slot(i);
                    m = i - 1;
                end
                if (m < first_free_idx) begin
                    first_free_idx  = m;
                    first_free_addr = addr;
                end
                return ST_OK;
            end
            addr += tbl_size[i];
        end
        return ST_UNKNOWN;
    endfunction

    function automatic t_status model_grow(input logic [31:0] bytes_in);
        logic [31:0] bytes;
        bytes = bytes_in;
        if (bytes > 32'hFFFF_FFFF - heap_total)
            bytes = 32'hFFFF_FFFF - heap_total;
        if (bytes == 0)
            return ST_OK;
        if (tbl_count > 0 && !tbl_res[tbl_count-1])
            tbl_size[tbl_count-1] += bytes;
        else begin
            if (tbl_count >= MAX_REGIONS)
                return ST_FULL;
            tbl_size[tbl_count] = bytes;
            tbl_res[tbl_count]  = 1'b0;
            tbl_count++;
        end
        heap_total += bytes;
        return ST_OK;
    endfunction

    function automatic heap_reply_t predict_reply(input heap_row_t r);
        heap_reply_t p;
        p.addr = '0;
        p.grow = '0;
        p.st   = ST_OK;
        case (r.op)
            OP_ALLOC: p.st = model_alloc(r.size, r.align, r.mode, p.addr, p.grow);
            OP_FREE:  p.st = model_free(r.faddr);
            OP_GROW:  p.st = model_grow(r.size);
            default:  p.st = ST_OK;
        endcase
        if (p.st != ST_OK)
            p.addr = '0;
        if (p.st != ST_NOFIT)
            p.grow = '0;
        p.heap = heap_total;
        return p;
    endfunction

    // Hold valid across back-to-back requests; drop it only for a real gap
    task automatic send_request(input heap_row_t r, output heap_reply_t got);
        int  gap;
        bit  taken;
        gap = steady ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 2));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= r.op;
        req_ch.size          <= r.size;
        req_ch.align_bytes   <= r.align;
        req_ch.boundary_mode <= r.mode;
        req_ch.free_addr     <= r.faddr;
        do begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        got = predict_reply(r);
        if (got.st == ST_OK && r.op == OP_ALLOC)
            live_addrs.push_back(got.addr);
        if (got.st == ST_OK && r.op == OP_FREE)
            foreach (live_addrs[k])
                if (live_addrs[k] == r.faddr) begin
                    live_addrs.delete(k);
                    break;
                end
        replies_due.push_back(r.typed ? r.want : got);
        items_sent++;
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        bit taken;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do begin
            @(negedge i_clk);
            taken = cfg_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        if (idx == CFG_HEAP_BASE) begin
            foreach (live_addrs[k])
                live_addrs[k] += val - base_reg;
            first_free_addr += val - base_reg;
            base_reg         = val;
        end else
            min_grow_reg = val;
    endtask

    // Drop valid and hold until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic heap_row_t mk_row(input t_opcode op, input logic [31:0] size,
                                         input logic [16:0] align, input t_bnd_mode mode,
                                         input logic [31:0] faddr);
        heap_row_t r;
        r.op    = op;
        r.size  = size;
        r.align = align;
        r.mode  = mode;
        r.faddr = faddr;
        r.typed = 1'b0;
        r.want  = '{32'd0, ST_OK, 32'd0, 32'd0};
        return r;
    endfunction

    function automatic heap_row_t mk_typed(input heap_row_t r, input logic [31:0] a,
                                           input t_status st, input logic [31:0] g,
                                           input logic [31:0] h);
        heap_row_t t;
        t       = r;
        t.typed = 1'b1;
        t.want  = '{a, st, g, h};
        return t;
    endfunction

    function automatic logic [16:0] rand_align();
        int c;
        c = $urandom_range(0, 9);
        if (c < 3)
            return 17'(c % 2);
        if (c < 8)
            return 17'd1 << $urandom_range(2, 16);
        return 17'($urandom);
    endfunction

    function automatic logic [31:0] rand_size();
        int c;
        c = $urandom_range(0, 99);
        if (c < 80)
            return $urandom_range(0, 256);
        if (c < 96)
            return $urandom_range(257, 70000);
        if (c < 98)
            return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
        return $urandom;
    endfunction

    // Allocate; on no fit, grow by the suggestion and retry once if it is within GROW_CAP
    task automatic alloc_with_grow(input heap_row_t r);
        heap_reply_t got;
        heap_reply_t dummy;
        send_request(r, got);
        if (got.st == ST_NOFIT && got.grow <= GROW_CAP) begin
            send_request(mk_row(OP_GROW, got.grow, 17'd0, BND_NONE, 32'd0), dummy);
            send_request(r, got);
        end
    endtask

    task automatic random_item();
        heap_reply_t got;
        int          c;
        int          k;
        logic [31:0] a;
        c = $urandom_range(0, 99);
        if (c < 55)
            alloc_with_grow(mk_row(OP_ALLOC, rand_size(), rand_align(),
                                   t_bnd_mode'($urandom_range(0, 3)), $urandom));
        else if (c < 85) begin
            if (live_addrs.size() != 0 && $urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, live_addrs.size() - 1);
                a = live_addrs[k];
            end else if ($urandom_range(0, 1) == 0)
                a = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
            else
                a = base_reg + ($urandom_range(0, 4096) & ~32'd3);
            send_request(mk_row(OP_FREE, $urandom, rand_align(),
                                t_bnd_mode'($urandom_range(0, 3)), a), got);
        end else if (c < 95)
            send_request(mk_row(OP_GROW, $urandom_range(0, 8192), rand_align(),
                                t_bnd_mode'($urandom_range(0, 3)), $urandom), got);
        else
            send_request(mk_row(t_opcode'($urandom_range(0, 3)), $urandom, 17'($urandom),
                                t_bnd_mode'($urandom_range(0, 3)), $urandom), got);
    endtask

    // Response side: random stalls, mostly short runs, a few long ones; none in the steady phase
    int rdy_run   = 0;
    bit rdy_level = 1'b1;
    always @(posedge i_clk) begin
        if (rdy_run == 0) begin
            rdy_level = $urandom_range(0, 3) != 0;
            if (rdy_level)
                rdy_run = $urandom_range(1, 20);
            else
                rdy_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 3);
        end else
            rdy_run--;
        rsp_ch.ready <= rdy_level || steady;
    end

    // Compare each response with the oldest prediction
    always @(negedge i_clk) begin
        heap_reply_t exp_r;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (replies_due.size() == 0)
                report("response with nothing outstanding");
            else begin
                exp_r = replies_due.pop_front();
                if (rsp_ch.result_addr !== exp_r.addr)
                    report($sformatf("result_addr %h, want %h", rsp_ch.result_addr, exp_r.addr));
                if (rsp_ch.status !== exp_r.st)
                    report($sformatf("status %0d, want %0d", rsp_ch.status, exp_r.st));
                if (rsp_ch.grow_bytes !== exp_r.grow)
                    report($sformatf("grow_bytes %h, want %h", rsp_ch.grow_bytes, exp_r.grow));
                if (rsp_ch.heap_bytes !== exp_r.heap)
                    report($sformatf("heap_bytes %h, want %h", rsp_ch.heap_bytes, exp_r.heap));
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(negedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCH_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        heap_row_t   dir_rows[$];
        heap_reply_t got;
        logic [31:0] phase_base [6];
        logic [31:0] phase_min  [6];
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_NOP;
        req_ch.size          <= '0;
        req_ch.align_bytes   <= '0;
        req_ch.boundary_mode <= BND_NONE;
        req_ch.free_addr     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_HEAP_BASE;
        cfg_ch.data          <= '0;
        // model reset state
        tbl_count       = 0;
        first_free_idx  = 0;
        base_reg        = 32'd0;
        first_free_addr = 32'd0;
        heap_total      = 32'd0;
        min_grow_reg    = 32'd65536;
        foreach (tbl_size[k]) begin
            tbl_size[k] = '0;
            tbl_res[k]  = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: extremes, every opcode and the corner cases
        dir_rows.push_back(mk_typed(mk_row(OP_ALLOC, 32'd16, 17'd0, BND_NONE, 32'd0),
                                    32'd0, ST_NOFIT, 32'd65536, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_FREE, 32'd0, 17'd0, BND_NONE, 32'd0),
                                    32'd0, ST_OK, 32'd0, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_FREE, 32'd0, 17'd0, BND_NONE, 32'h1234),
                                    32'd0, ST_UNKNOWN, 32'd0, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_GROW, 32'd0, 17'd0, BND_NONE, 32'd0),
                                    32'd0, ST_OK, 32'd0, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_NOP, 32'd77, 17'h1FFFF, BND_NONE2, 32'hFFFF_FFFF),
                                    32'd0, ST_OK, 32'd0, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_GROW, 32'h10000, 17'd0, BND_NONE, 32'd0),
                                    32'd0, ST_OK, 32'd0, 32'h10000));
        dir_rows.push_back(mk_typed(mk_row(OP_ALLOC, 32'd0, 17'd0, BND_NONE, 32'd0),
                                    32'd0, ST_OK, 32'd0, 32'h10000));
        dir_rows.push_back(mk_row(OP_ALLOC, 32'd5, 17'd3, BND_NONE2, 32'd0));
        dir_rows.push_back(mk_row(OP_ALLOC, 32'd100, 17'h10000, BND_SEG, 32'd0));
        dir_rows.push_back(mk_row(OP_ALLOC, 32'd100, 17'd4096, BND_PAGE, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_ALLOC, 32'hFFFF_FFFF, 17'h1FFFF, BND_NONE, 32'd0),
                                    32'd0, ST_NOFIT, 32'hFFFF_FFFF, 32'h10000));
        dir_rows.push_back(mk_row(OP_ALLOC, 32'd40000, 17'd1, BND_NONE, 32'd0));
        dir_rows.push_back(mk_typed(mk_row(OP_FREE, 32'd0, 17'd0, BND_NONE, 32'hFFFF_FFFF),
                                    32'd0, ST_UNKNOWN, 32'd0, 32'h10000));
        dir_rows.push_back(mk_typed(mk_row(OP_GROW, 32'h1000, 17'd0, BND_NONE, 32'd0),
                                    32'd0, ST_OK, 32'd0, 32'h11000));
        dir_rows.push_back(mk_row(OP_ALLOC, 32'h1000, 17'd16, BND_PAGE, 32'd0));
        dir_rows.push_back(mk_row(OP_FREE, 32'd0, 17'd0, BND_NONE, 32'd8));
        dir_rows.push_back(mk_row(OP_ALLOC, 32'd8, 17'h10000, BND_NONE, 32'd0));
        dir_rows.push_back(mk_row(OP_FREE, 32'd0, 17'd0, BND_NONE, 32'h10000));
        foreach (dir_rows[k])
            send_request(dir_rows[k], got);

        // Random phases, each under its own register setting
        phase_base = '{32'd0, 32'hFFFF_FFF0, 32'h8000_0000, $urandom & ~32'd3,
                       32'h0000_1000, 32'hFFFF_FFFF};
        phase_min  = '{32'd65536, 32'd0, 32'd4096, $urandom_range(0, 32'h10_0000),
                       32'h20000, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 6; ph++) begin
            drain_responses();
            write_reg(CFG_HEAP_BASE, phase_base[ph]);
            write_reg(CFG_MIN_GROWTH, phase_min[ph]);
            cfg_ch.valid <= 1'b0;
            steady = (ph == 2);
            while (items_sent < ITEM_TARGET * (ph + 1) / 6)
                random_item();
        end

        // Heap size overflow: clip to 32 bits, then a grow that clips to nothing
        send_request(mk_row(OP_GROW, 32'hFFFF_FFFF, 17'd0, BND_NONE, 32'd0), got);
        send_request(mk_row(OP_GROW, 32'd3, 17'd0, BND_NONE, 32'd0), got);
        repeat (20)
            random_item();

        drain_responses();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
sv/rtha_pkg.sv
sv/rtha_req_if.sv
sv/rtha_rsp_if.sv
sv/rtha_cfg_if.sv
sv/rtha_ram.sv
sv/region_table_heap_allocator.sv
tb/sv/tb_region_table_heap_allocator.sv
